>>> sv/lcdtx_pkg.sv
// Package for the serial LCD command transmitter.
// Holds the command codes, the result struct, the line constants and the
// byte and bit-time functions. No dependencies.
`default_nettype none

package lcdtx_pkg;

    typedef enum logic [2:0] {
        CMD_TICK       = 3'd0,
        CMD_PRINT      = 3'd1,
        CMD_GOTO       = 3'd2,
        CMD_CLEAR      = 3'd3,
        CMD_CLEAR_LINE = 3'd4
    } cmd_t;

    typedef struct packed {
        logic level;
        logic busy;
        logic rej;
    } res_t;

    localparam int unsigned PADDR_W = 3;
    localparam logic [PADDR_W-1:0] REG_BIT_TUNE_ADDR = 3'd0;
    localparam logic [7:0] BIT_TUNE_RESET = 8'd51;

    localparam logic [7:0] LCD_PREFIX     = 8'hFE;
    localparam logic [7:0] LCD_ROW0_BASE  = 8'h80;
    localparam logic [7:0] LCD_ROW1_OFS   = 8'h30;
    localparam logic [7:0] LCD_CLEAR      = 8'h01;
    localparam logic [7:0] LCD_SPACE      = 8'h20;
    localparam logic [7:0] ROW_CHARS      = 8'd16;
    localparam logic [7:0] ROW_LIMIT      = 8'd32;

    localparam logic [7:0] BIT_TIME_MIN     = 8'd96;
    localparam logic [7:0] BIT_TIME_MAX     = 8'd108;
    localparam logic [6:0] BIT_TIME_DEFAULT = 7'd102;

    localparam logic [3:0] BIT_START = 4'd0;
    localparam logic [3:0] BIT_STOP  = 4'd9;

    function automatic logic [6:0] bit_time(input logic [7:0] tune);
        logic [7:0] d;
        d = {tune[6:0], 1'b0};
        if (d >= BIT_TIME_MIN && d <= BIT_TIME_MAX)
            return d[6:0];
        return BIT_TIME_DEFAULT;
    endfunction

    function automatic logic [7:0] seq_byte(input cmd_t cmd, input logic [7:0] arg,
                                            input logic idx_zero, input logic idx_one);
        logic [7:0] b;
        b = LCD_SPACE;
        if (cmd == CMD_PRINT)
            b = arg;
        else if (idx_zero)
            b = LCD_PREFIX;
        else if (cmd == CMD_GOTO)
        begin
            if (arg < ROW_CHARS)
                b = arg + LCD_ROW0_BASE;
            else if (arg < ROW_LIMIT)
                b = arg + LCD_ROW0_BASE + LCD_ROW1_OFS;
            else
                b = LCD_ROW0_BASE;
        end
        else if (cmd == CMD_CLEAR)
            b = LCD_CLEAR;
        else if (idx_one)
            b = {arg[3:0], 4'b0000} | LCD_ROW0_BASE;
        return b;
    endfunction

endpackage

`default_nettype wire

>>> sv/lcdtx_apb.sv
// Configuration register file: holds the bit_tune register behind an
// APB-style write/read port. Uses lcdtx_pkg.
`default_nettype none

module lcdtx_apb
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [lcdtx_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready,
    output logic      [7:0]                    bit_tune
);

    logic [7:0] bit_tune_reg;
    logic [7:0] bit_tune_next;
    logic       hit;

    assign pready = 1'b1;
    assign hit    = (paddr == lcdtx_pkg::REG_BIT_TUNE_ADDR);

    always_comb
    begin
        bit_tune_next = bit_tune_reg;
        if (psel && penable && pwrite && hit)
            bit_tune_next = pwdata[7:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bit_tune_reg <= lcdtx_pkg::BIT_TUNE_RESET;
        else
            bit_tune_reg <= bit_tune_next;
    end

    assign prdata   = hit ? {24'd0, bit_tune_reg} : 32'd0;
    assign bit_tune = bit_tune_reg;

endmodule

`default_nettype wire

>>> sv/lcdtx_seq.sv
// Command sequencer: expands a command into LCD bytes and walks each byte
// through start, data and stop bits, one tick per step. Uses lcdtx_pkg.
`default_nettype none

module lcdtx_seq #(
    parameter int unsigned LINE_CHARS = 16
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  step,
    input  wire logic [2:0]            command,
    input  wire logic [7:0]            arg_byte,
    input  wire logic [6:0]            bit_time,
    output lcdtx_pkg::res_t            res
);

    localparam int unsigned BW = $clog2(LINE_CHARS + 3);

    lcdtx_pkg::cmd_t active_cmd_reg, active_cmd_next;
    logic [7:0]      arg_hold_reg, arg_hold_next;
    logic [BW-1:0]   byte_index_reg, byte_index_next;
    logic [3:0]      bit_index_reg, bit_index_next;
    logic [6:0]      tick_count_reg, tick_count_next;
    logic [7:0]      shift_byte_reg, shift_byte_next;

    logic            cmd_ok;
    logic            idle;
    logic [BW-1:0]   seq_len;
    logic [BW-1:0]   byte_inc;
    logic [6:0]      tick_inc;
    logic [2:0]      data_sel;

    assign cmd_ok = (command >= 3'(lcdtx_pkg::CMD_PRINT))
                 && (command <= 3'(lcdtx_pkg::CMD_CLEAR_LINE));
    assign idle   = (active_cmd_reg == lcdtx_pkg::CMD_TICK);

    always_comb
    begin
        active_cmd_next = active_cmd_reg;
        arg_hold_next   = arg_hold_reg;
        byte_index_next = byte_index_reg;
        bit_index_next  = bit_index_reg;
        tick_count_next = tick_count_reg;
        shift_byte_next = shift_byte_reg;
        res             = '{level: 1'b1, busy: 1'b0, rej: 1'b0};
        seq_len         = '0;
        byte_inc        = '0;
        tick_inc        = '0;
        data_sel        = '0;

        if (idle)
        begin
            if (cmd_ok)
            begin
                active_cmd_next = lcdtx_pkg::cmd_t'(command);
                arg_hold_next   = arg_byte;
                byte_index_next = '0;
                bit_index_next  = lcdtx_pkg::BIT_START;
                tick_count_next = '0;
                shift_byte_next = lcdtx_pkg::seq_byte(lcdtx_pkg::cmd_t'(command),
                                                      arg_byte, 1'b1, 1'b0);
            end
        end
        else if (cmd_ok)
            res.rej = 1'b1;

        if (active_cmd_next != lcdtx_pkg::CMD_TICK)
        begin
            res.busy = 1'b1;
            data_sel = 3'(bit_index_next - 4'd1);
            if (bit_index_next == lcdtx_pkg::BIT_START)
                res.level = 1'b0;
            else if (bit_index_next < lcdtx_pkg::BIT_STOP)
                res.level = shift_byte_next[data_sel];
            else
                res.level = 1'b1;

            case (active_cmd_next)
                lcdtx_pkg::CMD_PRINT:      seq_len = BW'(1);
                lcdtx_pkg::CMD_GOTO:       seq_len = BW'(2);
                lcdtx_pkg::CMD_CLEAR:      seq_len = BW'(2);
                lcdtx_pkg::CMD_CLEAR_LINE: seq_len = BW'(LINE_CHARS + 2);
                default:                   seq_len = '0;
            endcase

            tick_inc = tick_count_next + 7'd1;
            byte_inc = byte_index_next + BW'(1);
            if (tick_inc >= bit_time)
            begin
                tick_count_next = '0;
                if (bit_index_next == lcdtx_pkg::BIT_STOP)
                begin
                    bit_index_next = lcdtx_pkg::BIT_START;
                    if (byte_inc >= seq_len)
                    begin
                        active_cmd_next = lcdtx_pkg::CMD_TICK;
                        byte_index_next = '0;
                    end
                    else
                    begin
                        byte_index_next = byte_inc;
                        shift_byte_next = lcdtx_pkg::seq_byte(active_cmd_next,
                                              arg_hold_next, 1'b0, byte_inc == BW'(1));
                    end
                end
                else
                    bit_index_next = bit_index_next + 4'd1;
            end
            else
                tick_count_next = tick_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_cmd_reg <= lcdtx_pkg::CMD_TICK;
            arg_hold_reg   <= '0;
            byte_index_reg <= '0;
            bit_index_reg  <= '0;
            tick_count_reg <= '0;
            shift_byte_reg <= '0;
        end
        else if (step)
        begin
            active_cmd_reg <= active_cmd_next;
            arg_hold_reg   <= arg_hold_next;
            byte_index_reg <= byte_index_next;
            bit_index_reg  <= bit_index_next;
            tick_count_reg <= tick_count_next;
            shift_byte_reg <= shift_byte_next;
        end
    end

    a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
        bit_index_reg <= lcdtx_pkg::BIT_STOP)
        else $error("bit index past stop bit");

    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        idle |-> (bit_index_reg == 4'd0 && tick_count_reg == 7'd0
                  && byte_index_reg == '0))
        else $error("counters not cleared while idle");

    a_tick_range: assert property (@(posedge clk) disable iff (!rst_n)
        tick_count_reg < 7'(lcdtx_pkg::BIT_TIME_MAX))
        else $error("tick count past longest bit time");

endmodule

`default_nettype wire

>>> sv/serial_lcd_command_transmitter_unit.sv
// Serial LCD command transmitter: every input item is one microsecond tick
// of the serial line and yields one result item (line level, busy, rejected).
// Uses lcdtx_pkg, lcdtx_apb and lcdtx_seq.
//
// An item is taken every cycle while in_stall is low; each one passes an
// input register, the sequencer step (byte expansion, 8N1 bit walk, tick
// count) and a result register. Commands 1..4 start a byte sequence if the
// line is idle and are flagged rejected otherwise; codes 0 and 5..7 only
// advance time. Bit time is 2*bit_tune (8-bit) when in 96..108 ticks, else
// 102; write bit_tune only while no item is in the pipeline. A new bit time
// applies from the next tick, even in the middle of a bit.
`default_nettype none

module serial_lcd_command_transmitter_unit #(
    parameter int unsigned LINE_CHARS = 16
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [lcdtx_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [2:0]                    command,
    input  wire logic [7:0]                    arg_byte,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               tx_line,
    output logic                               busy_res,
    output logic                               rejected
);

    logic [7:0]       bit_tune;
    logic             s1_valid_reg, s1_valid_next;
    logic [2:0]       command_reg;
    logic [7:0]       arg_in_reg;
    logic             out_valid_reg, out_valid_next;
    lcdtx_pkg::res_t  result_reg;
    lcdtx_pkg::res_t  step_res;
    logic             s1_advance;
    logic             accept;

    lcdtx_apb u_apb (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .bit_tune (bit_tune)
    );

    lcdtx_seq #(
        .LINE_CHARS (LINE_CHARS)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (s1_advance),
        .command  (command_reg),
        .arg_byte (arg_in_reg),
        .bit_time (lcdtx_pkg::bit_time(bit_tune)),
        .res      (step_res)
    );

    assign s1_advance = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall   = s1_valid_reg && !s1_advance;
    assign accept     = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = 1'b1;
        else if (s1_advance)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (s1_advance)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            command_reg <= command;
            arg_in_reg  <= arg_byte;
        end
        if (s1_advance)
            result_reg <= step_res;
    end

    assign out_valid = out_valid_reg;
    assign tx_line   = result_reg.level;
    assign busy_res  = result_reg.busy;
    assign rejected  = result_reg.rej;

    a_rej_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && rejected) |-> busy_res)
        else $error("rejected item reported while idle");

    a_idle_high: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !busy_res) |-> tx_line)
        else $error("line low while idle");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid_reg && s1_valid_reg))
        else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// Testbench for serial_lcd_command_transmitter_unit: drives tick items through
// the input channel, predicts every line sample and checks it on the output.
// Depends on lcdtx_pkg and the unit's RTL only.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_CHARS = 16;
    localparam logic [2:0] CMD_SPARE_LO = 3'd5;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES = 400;
    localparam int WATCHDOG_LIMIT = 4000;

    class lcd_line_scoreboard;
        logic [7:0]        tune;
        lcdtx_pkg::cmd_t   cur_cmd;
        logic [7:0]        arg_hold;
        int                byte_pos;
        int                bit_pos;
        int                bit_ticks;
        logic [7:0]        cur_byte;
        lcdtx_pkg::res_t   line_samples_q[$];
        int                fail_count;

        function new();
            tune = lcdtx_pkg::BIT_TUNE_RESET;
            cur_cmd = lcdtx_pkg::CMD_TICK;
            arg_hold = '0;
            byte_pos = 0;
            bit_pos = 0;
            bit_ticks = 0;
            cur_byte = '0;
            fail_count = 0;
        endfunction

        function void set_tune(logic [7:0] value);
            tune = value;
        endfunction

        function bit line_busy();
            return cur_cmd != lcdtx_pkg::CMD_TICK;
        endfunction

        function int outstanding();
            return line_samples_q.size();
        endfunction

        function int ticks_per_bit();
            logic [7:0] twice;
            twice = {tune[6:0], 1'b0};
            if (twice >= lcdtx_pkg::BIT_TIME_MIN && twice <= lcdtx_pkg::BIT_TIME_MAX)
                return int'(twice);
            return int'(lcdtx_pkg::BIT_TIME_DEFAULT);
        endfunction

        function int bytes_in(lcdtx_pkg::cmd_t c);
            case (c)
                lcdtx_pkg::CMD_PRINT:      return 1;
                lcdtx_pkg::CMD_GOTO:       return 2;
                lcdtx_pkg::CMD_CLEAR:      return 2;
                lcdtx_pkg::CMD_CLEAR_LINE: return 2 + LINE_CHARS;
                default:                   return 0;
            endcase
        endfunction

        function logic [7:0] char_at(lcdtx_pkg::cmd_t c, logic [7:0] a, int idx);
            if (c == lcdtx_pkg::CMD_PRINT)
                return a;
            if (idx == 0)
                return lcdtx_pkg::LCD_PREFIX;
            case (c)
                lcdtx_pkg::CMD_GOTO:
                begin
                    if (a < lcdtx_pkg::ROW_CHARS)
                        return a + lcdtx_pkg::LCD_ROW0_BASE;
                    if (a < lcdtx_pkg::ROW_LIMIT)
                        return a + lcdtx_pkg::LCD_ROW0_BASE + lcdtx_pkg::LCD_ROW1_OFS;
                    return lcdtx_pkg::LCD_ROW0_BASE;
                end
                lcdtx_pkg::CMD_CLEAR:
                    return lcdtx_pkg::LCD_CLEAR;
                default:
                begin
                    if (idx == 1)
                        return {a[3:0], 4'b0000} | lcdtx_pkg::LCD_ROW0_BASE;
                    return lcdtx_pkg::LCD_SPACE;
                end
            endcase
        endfunction

        function void note_item(logic [2:0] c, logic [7:0] a);
            bit              real_cmd;
            lcdtx_pkg::res_t r;
            real_cmd = (c >= lcdtx_pkg::CMD_PRINT && c <= lcdtx_pkg::CMD_CLEAR_LINE);
            r.level = 1'b1;
            r.busy = 1'b0;
            r.rej = 1'b0;
            if (cur_cmd == lcdtx_pkg::CMD_TICK)
            begin
                if (real_cmd)
                begin
                    cur_cmd = lcdtx_pkg::cmd_t'(c);
                    arg_hold = a;
                    byte_pos = 0;
                    bit_pos = 0;
                    bit_ticks = 0;
                    cur_byte = char_at(cur_cmd, a, 0);
                end
            end
            else if (real_cmd)
                r.rej = 1'b1;
            if (cur_cmd != lcdtx_pkg::CMD_TICK)
            begin
                r.busy = 1'b1;
                if (bit_pos == 0)
                    r.level = 1'b0;
                else if (bit_pos <= 8)
                    r.level = cur_byte[bit_pos-1];
                bit_ticks++;
                if (bit_ticks >= ticks_per_bit())
                begin
                    bit_ticks = 0;
                    bit_pos++;
                    if (bit_pos > 9)
                    begin
                        bit_pos = 0;
                        byte_pos++;
                        if (byte_pos >= bytes_in(cur_cmd))
                        begin
                            cur_cmd = lcdtx_pkg::CMD_TICK;
                            byte_pos = 0;
                        end
                        else
                            cur_byte = char_at(cur_cmd, arg_hold, byte_pos);
                    end
                end
            end
            line_samples_q.push_back(r);
        endfunction

        function void check_result(lcdtx_pkg::res_t got);
            lcdtx_pkg::res_t want;
            if (line_samples_q.size() == 0)
            begin
                $error("result item with no item pending");
                fail_count++;
                return;
            end
            want = line_samples_q.pop_front();
            if (got.level !== want.level)
            begin
                $error("tx_line: expected %0b, got %0b", want.level, got.level);
                fail_count++;
            end
            if (got.busy !== want.busy)
            begin
                $error("busy_res: expected %0b, got %0b", want.busy, got.busy);
                fail_count++;
            end
            if (got.rej !== want.rej)
            begin
                $error("rejected: expected %0b, got %0b", want.rej, got.rej);
                fail_count++;
            end
        endfunction
    endclass

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [lcdtx_pkg::PADDR_W-1:0]   paddr;
    logic [31:0]                     pwdata;
    logic [31:0]                     prdata;
    logic                            pready;
    logic                            in_valid;
    logic                            in_stall;
    logic [2:0]                      command;
    logic [7:0]                      arg_byte;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    logic                            tx_line;
    logic                            busy_res;
    logic                            rejected;

    int                   send_idle_pct = 0;
    int                   stall_pct = 0;
    bit                   hold_req = 1'b0;
    int                   hold_left = 0;
    int                   quiet_cycles;
    lcd_line_scoreboard   board;

    serial_lcd_command_transmitter_unit #(
        .LINE_CHARS(LINE_CHARS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .command(command),
        .arg_byte(arg_byte),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .tx_line(tx_line),
        .busy_res(busy_res),
        .rejected(rejected)
    );

    always #5 clk = ~clk;

    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            board.check_result(lcdtx_pkg::res_t'{tx_line, busy_res, rejected});

    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || psel || (in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    task automatic send_item(input logic [2:0] c, input logic [7:0] a);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        command <= c;
        arg_byte <= a;
        do
            @(posedge clk);
        while (in_stall);
        board.note_item(c, a);
        @(negedge clk);
    endtask

    // pick a tick while idle; while busy a tick, a spare code or a command to be dropped
    task automatic send_filler();
        int pick;
        pick = $urandom_range(99);
        if (pick < 85 || !board.line_busy())
            send_item(lcdtx_pkg::CMD_TICK, 8'($urandom_range(255)));
        else if (pick < 95)
            send_item(3'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO)), 8'($urandom_range(255)));
        else
            send_item(3'($urandom_range(lcdtx_pkg::CMD_CLEAR_LINE, lcdtx_pkg::CMD_PRINT)),
                      8'($urandom_range(255)));
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (board.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_tune(input logic [7:0] value);
        logic [31:0] word;
        word = $urandom();
        word[7:0] = value;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= lcdtx_pkg::REG_BIT_TUNE_ADDR;
        pwdata <= word;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        board.set_tune(value);
        @(negedge clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata[7:0] !== value)
        begin
            $error("bit_tune readback: expected %0d, got %0d", value, prdata[7:0]);
            board.fail_count++;
        end
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic run_phase(input int idle_pct, input int busy_pct, input logic [7:0] tune,
                             input bit with_hold, input lcdtx_pkg::cmd_t c,
                             input logic [7:0] a, input int fillers);
        int noise;
        write_tune(tune);
        send_idle_pct = idle_pct;
        stall_pct = busy_pct;
        noise = $urandom_range(3);
        repeat (noise)
        begin
            if ($urandom_range(1))
                send_item(lcdtx_pkg::CMD_TICK, 8'($urandom_range(255)));
            else
                send_item(3'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO)), 8'($urandom_range(255)));
        end
        send_item(c, a);
        for (int i = 0; i < fillers; i++)
        begin
            if (with_hold && i == fillers / 4)
                hold_req = 1'b1;
            send_filler();
        end
        drain_results();
    endtask

    initial
    begin
        board = new();
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        command = lcdtx_pkg::CMD_TICK;
        arg_byte = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (logic [3:0] k = CMD_SPARE_LO; k <= CMD_SPARE_HI; k++)
            send_item(k[2:0], 8'hA5);
        drain_results();

        // a whole print sequence, back to idle afterwards
        run_phase(0, 0, 8'd48, 1'b1, lcdtx_pkg::CMD_PRINT, 8'h96, 1000);

        // lengthen the bit time to the largest valid value, then a goto into the second row
        write_tune(8'd54);
        send_item(lcdtx_pkg::CMD_GOTO, 8'd20);
        repeat (100) send_item(lcdtx_pkg::CMD_TICK, 8'h00);
        drain_results();

        run_phase(68, 0, 8'd48, 1'b0, lcdtx_pkg::CMD_CLEAR, 8'h00, 150);
        run_phase(0, 68, 8'd0, 1'b1, lcdtx_pkg::CMD_CLEAR_LINE, 8'hFF, 250);
        run_phase(33, 33, 8'd53, 1'b0, lcdtx_pkg::CMD_PRINT, 8'h3C, 250);

        while (board.outstanding() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (board.fail_count == 0 && board.outstanding() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

>>> files.f
sv/lcdtx_pkg.sv
sv/lcdtx_apb.sv
sv/lcdtx_seq.sv
sv/serial_lcd_command_transmitter_unit.sv
tb/tb_top.sv
